// File: hw/rtl/greedy_graph_colorer_defines.svh
// Assertion macros shared by the greedy graph colorer RTL.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef GREEDY_GRAPH_COLORER_DEFINES_SVH
`define GREEDY_GRAPH_COLORER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GGC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define GGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ggc_pkg.sv
// Package of the greedy graph colorer: field widths, codes and payload types.
// No dependencies; used by the interfaces, the RAM wrapper users and the top level.
package ggc_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int ROW_W    = 64;
    localparam int INDEX_W  = 6;
    localparam int VERTEX_W = 6;
    localparam int COLOR_W  = 6;
    localparam int TRIES_W  = 13;
    localparam int COUNT_W  = 7;
    localparam int MODE_W   = 2;
    localparam int SAT_W    = 7;
    localparam int DEG_W    = 7;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [MODE_W-1:0] MODE_INDEX  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEGREE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SAT    = 2'd2;

    localparam logic REG_VCOUNT = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [TRIES_W-1:0]  tries_t;

endpackage

// File: hw/rtl/ggc_if.sv
// Valid/ready channel interfaces of the greedy graph colorer: command and result.
// Depends on ggc_pkg for field widths and types.
interface ggc_cmd_if;
    import ggc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [INDEX_W-1:0]   row_index;
    row_t                 row_bits;

    modport source (output valid, output operation, output row_index, output row_bits,
                    input ready);
    modport sink   (input valid, input operation, input row_index, input row_bits,
                    output ready);
endinterface

interface ggc_result_if;
    import ggc_pkg::*;

    logic    valid;
    logic    ready;
    vertex_t vertex;
    color_t  color;
    tries_t  tries;
    logic    last;

    modport source (output valid, output vertex, output color, output tries, output last,
                    input ready);
    modport sink   (input valid, input vertex, input color, input tries, input last,
                    output ready);
endinterface

// File: hw/rtl/ggc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ggc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/greedy_graph_colorer.sv
// Top level of the greedy graph colorer: APB registers, sequencer and its stores.
// Depends on ggc_pkg, ggc_if.sv, ggc_ram and greedy_graph_colorer_defines.svh.
//
//   Channel   Direction  Beat contents
//   -------   ---------  ---------------------------------------------
//   cmd       in         operation, row_index, row_bits
//   result    out        vertex, color, tries, last
//   apb       in/out     vertex_count (0x0), order_mode (0x4)
//
// A load beat writes its row, then the row popcount runs a byte a cycle into the degree store.
// A start beat paints n vertices; each takes a scan over the n vertices to choose, color tries
// up to the first free color and a scan over the n vertices to update the neighbors, since
// every store has one read port and is walked one vertex per cycle.
// Reset clears control state and the per-entry valid bits, so no clearing pass is needed.
// cmd is held off while an item is in work; a stalled result only holds the sequencer
// once the next painted vertex is ready to go out.
`include "greedy_graph_colorer_defines.svh"

module greedy_graph_colorer #(
    parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ggc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ggc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ggc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    ggc_cmd_if.sink                          cmd,
    ggc_result_if.source                     result
);
    import ggc_pkg::*;

    // Widths that follow from the vertex limit.
    localparam int AW     = $clog2(MAX_VERTICES);
    localparam int CW     = $clog2(MAX_VERTICES + 1);
    localparam int NCHUNK = (MAX_VERTICES + 7) / 8;
    localparam int PADW   = NCHUNK * 8;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int RUNW   = MAX_VERTICES + SAT_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DEG    = 3'd1;
    localparam logic [2:0] S_CHOOSE = 3'd2;
    localparam logic [2:0] S_FETCH  = 3'd3;
    localparam logic [2:0] S_LATCH  = 3'd4;
    localparam logic [2:0] S_COLOR  = 3'd5;
    localparam logic [2:0] S_UPDATE = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    // Counts the set bits of one byte of the row being loaded.
    function automatic logic [3:0] pop8(input logic [7:0] x);
        logic [3:0] s;
        s = '0;
        for (int i = 0; i < 8; i++)
        begin
            s = s + {3'b000, x[i]};
        end
        return s;
    endfunction

    // Configuration registers.
    logic [COUNT_W-1:0] vcount_reg, vcount_next;
    logic [MODE_W-1:0]  mode_reg, mode_next;

    // Control state.
    logic [2:0]              state_reg, state_next;
    logic [CHW-1:0]          dg_chunk_reg, dg_chunk_next;
    logic [MAX_VERTICES-1:0] deg_valid_reg, deg_valid_next;
    logic [MAX_VERTICES-1:0] run_valid_reg, run_valid_next;
    logic [MAX_VERTICES-1:0] colored_reg, colored_next;
    logic [CW-1:0]           scan_reg, scan_next;
    logic                    pipe_vld_reg, pipe_vld_next;
    logic                    found_reg, found_next;
    logic [TRIES_W-1:0]      tries_reg, tries_next;
    logic [AW-1:0]           k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [PADW-1:0]         dg_row_reg, dg_row_next;
    logic [DEG_W-1:0]        dg_cnt_reg, dg_cnt_next;
    logic [AW-1:0]           dg_addr_reg, dg_addr_next;
    logic                    dg_ok_reg, dg_ok_next;
    logic [AW-1:0]           pipe_idx_reg, pipe_idx_next;
    logic [AW-1:0]           best_reg, best_next;
    logic [SAT_W-1:0]        best_key_reg, best_key_next;
    logic [MAX_VERTICES-1:0] adjv_reg, adjv_next;
    logic [MAX_VERTICES-1:0] used_reg, used_next;
    logic [AW-1:0]           j_reg, j_next;
    logic [AW-1:0]           color_reg, color_next;
    logic [AW-1:0]           out_vertex_reg, out_vertex_next;
    logic [AW-1:0]           out_color_reg, out_color_next;
    logic [TRIES_W-1:0]      out_tries_reg, out_tries_next;
    logic                    out_last_reg, out_last_next;

    // Working vertex count, saturated to 1..MAX_VERTICES, and the matching mask.
    logic [COUNT_W-1:0]      n_sat;
    logic [CW-1:0]           n_act;
    logic [AW-1:0]           n_m1;
    logic [MAX_VERTICES-1:0] vmask;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_sat = COUNT_W'(1);
        end
        else if (vcount_reg > COUNT_W'(MAX_VERTICES))
        begin
            n_sat = COUNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_sat = vcount_reg;
        end
    end

    assign n_act = CW'(n_sat);
    assign n_m1  = AW'(n_sat - COUNT_W'(1));

    always_comb
    begin
        for (int i = 0; i < MAX_VERTICES; i++)
        begin
            vmask[i] = (i < int'(n_sat));
        end
    end

    // APB port. Writes are registered; pready never drops.
    logic cfg_we;
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_VCOUNT: prdata = APB_DATA_W'(vcount_reg);
            REG_MODE:   prdata = APB_DATA_W'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    // Command channel.
    logic cmd_acc;
    logic load_acc;
    logic start_acc;
    logic row_in_range;

    assign cmd.ready    = (state_reg == S_IDLE);
    assign cmd_acc      = cmd.valid && cmd.ready;
    assign load_acc     = cmd_acc && (cmd.operation == OP_LOAD);
    assign start_acc    = cmd_acc && (cmd.operation == OP_START);
    assign row_in_range = ({1'b0, cmd.row_index} < (INDEX_W + 1)'(MAX_VERTICES));

    // The three stores share one read address: the scan position, or the chosen
    // vertex while its row and neighbor colors are fetched.
    logic [AW-1:0] rd_addr;
    assign rd_addr = (state_reg == S_FETCH) ? best_reg : scan_reg[AW-1:0];

    // Adjacency rows; bits at or above MAX_VERTICES can never matter and are dropped.
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic                    adj_we;
    assign adj_we = load_acc && row_in_range;

    ggc_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (cmd.row_index[AW-1:0]),
        .wdata (cmd.row_bits[MAX_VERTICES-1:0]),
        .raddr (rd_addr),
        .rdata (adj_rdata)
    );

    // Degree store, written at the end of a row load.
    logic [DEG_W-1:0] deg_rdata;
    logic [DEG_W-1:0] dg_sum;
    logic             dg_done;
    logic             deg_we;

    assign dg_sum  = dg_cnt_reg + DEG_W'(pop8(dg_row_reg[7:0]));
    assign dg_done = (dg_chunk_reg == CHW'(NCHUNK - 1));
    assign deg_we  = (state_reg == S_DEG) && dg_done && dg_ok_reg;

    ggc_ram #(
        .WIDTH (DEG_W),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (dg_addr_reg),
        .wdata (dg_sum),
        .raddr (rd_addr),
        .rdata (deg_rdata)
    );

    // Per-run store: saturation on top of the set of colors already seen among the
    // vertex's own row. Both start at zero for each run through the valid bits.
    logic [RUNW-1:0]         run_rdata;
    logic                    run_we;
    logic [RUNW-1:0]         run_wdata;
    logic                    run_ok;
    logic [SAT_W-1:0]        sat_rd;
    logic [MAX_VERTICES-1:0] cset_rd;
    logic [SAT_W-1:0]        sat_new;
    logic [MAX_VERTICES-1:0] cset_new;
    logic [DEG_W-1:0]        deg_rd;
    logic [SAT_W-1:0]        key;

    assign run_ok  = run_valid_reg[pipe_idx_reg];
    assign sat_rd  = run_ok ? run_rdata[RUNW-1 -: SAT_W] : '0;
    assign cset_rd = run_ok ? run_rdata[MAX_VERTICES-1:0] : '0;
    assign deg_rd  = deg_valid_reg[pipe_idx_reg] ? deg_rdata : '0;

    // A neighbor of the painted vertex gains saturation only if the new color is
    // not yet among its own colored neighbors. Every vertex whose row holds the
    // painted vertex learns the new color.
    assign sat_new  = sat_rd + SAT_W'(adjv_reg[pipe_idx_reg] && !cset_rd[color_reg]);
    assign cset_new = cset_rd
                    | (adj_rdata[best_reg] ? (MAX_VERTICES'(1) << color_reg) : '0);
    assign run_wdata = {sat_new, cset_new};
    assign run_we    = (state_reg == S_UPDATE) && pipe_vld_reg;

    ggc_ram #(
        .WIDTH (RUNW),
        .DEPTH (MAX_VERTICES)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (pipe_idx_reg),
        .wdata (run_wdata),
        .raddr (rd_addr),
        .rdata (run_rdata)
    );

    // Ordering key; index order and the unused mode compare all-equal keys, so the
    // first uncolored vertex wins.
    always_comb
    begin
        case (mode_reg)
            MODE_INDEX:  key = '0;
            MODE_DEGREE: key = SAT_W'(deg_rd);
            MODE_SAT:    key = sat_rd;
            default:     key = '0;
        endcase
    end

    logic out_free;
    logic scan_issue;
    logic scan_end;

    assign out_free   = !out_valid_reg || result.ready;
    assign scan_issue = (scan_reg < n_act);
    assign scan_end   = pipe_vld_reg && (pipe_idx_reg == n_m1);

    always_comb
    begin
        vcount_next     = vcount_reg;
        mode_next       = mode_reg;
        state_next      = state_reg;
        dg_chunk_next   = dg_chunk_reg;
        deg_valid_next  = deg_valid_reg;
        run_valid_next  = run_valid_reg;
        colored_next    = colored_reg;
        scan_next       = scan_reg;
        pipe_vld_next   = 1'b0;
        found_next      = found_reg;
        tries_next      = tries_reg;
        k_next          = k_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        dg_row_next     = dg_row_reg;
        dg_cnt_next     = dg_cnt_reg;
        dg_addr_next    = dg_addr_reg;
        dg_ok_next      = dg_ok_reg;
        pipe_idx_next   = rd_addr;
        best_next       = best_reg;
        best_key_next   = best_key_reg;
        adjv_next       = adjv_reg;
        used_next       = used_reg;
        j_next          = j_reg;
        color_next      = color_reg;
        out_vertex_next = out_vertex_reg;
        out_color_next  = out_color_reg;
        out_tries_next  = out_tries_reg;
        out_last_next   = out_last_reg;

        if (cfg_we)
        begin
            case (paddr[REG_SEL_BIT])
                REG_VCOUNT: vcount_next = pwdata[COUNT_W-1:0];
                REG_MODE:   mode_next   = pwdata[MODE_W-1:0];
                default:    ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    dg_row_next   = PADW'(cmd.row_bits[MAX_VERTICES-1:0] & vmask);
                    dg_cnt_next   = '0;
                    dg_chunk_next = '0;
                    dg_addr_next  = cmd.row_index[AW-1:0];
                    dg_ok_next    = row_in_range;
                    state_next    = S_DEG;
                end
                else if (start_acc)
                begin
                    colored_next   = '0;
                    run_valid_next = '0;
                    tries_next     = '0;
                    k_next         = '0;
                    found_next     = 1'b0;
                    scan_next      = '0;
                    state_next     = S_CHOOSE;
                end
            end

            S_DEG:
            begin
                dg_cnt_next   = dg_sum;
                dg_row_next   = dg_row_reg >> 8;
                dg_chunk_next = dg_chunk_reg + CHW'(1);
                if (dg_done)
                begin
                    if (dg_ok_reg)
                    begin
                        deg_valid_next[dg_addr_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_CHOOSE:
            begin
                if (scan_issue)
                begin
                    pipe_vld_next = 1'b1;
                    scan_next     = scan_reg + CW'(1);
                end
                if (pipe_vld_reg && !colored_reg[pipe_idx_reg]
                    && (!found_reg || (key > best_key_reg)))
                begin
                    best_next     = pipe_idx_reg;
                    best_key_next = key;
                    found_next    = 1'b1;
                end
                if (scan_end)
                begin
                    state_next = S_FETCH;
                end
            end

            S_FETCH:
            begin
                state_next = S_LATCH;
            end

            S_LATCH:
            begin
                adjv_next  = adj_rdata & vmask;
                used_next  = cset_rd;
                j_next     = '0;
                state_next = S_COLOR;
            end

            S_COLOR:
            begin
                tries_next = tries_reg + TRIES_W'(1);
                if (!used_reg[j_reg] || (j_reg == n_m1))
                begin
                    color_next = j_reg;
                    scan_next  = '0;
                    state_next = S_UPDATE;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end

            S_UPDATE:
            begin
                if (scan_issue)
                begin
                    pipe_vld_next = 1'b1;
                    scan_next     = scan_reg + CW'(1);
                end
                if (pipe_vld_reg)
                begin
                    run_valid_next[pipe_idx_reg] = 1'b1;
                end
                if (scan_end)
                begin
                    colored_next[best_reg] = 1'b1;
                    state_next             = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = best_reg;
                    out_color_next  = color_reg;
                    out_tries_next  = tries_reg;
                    out_last_next   = (k_reg == n_m1);
                    if (k_reg == n_m1)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        found_next = 1'b0;
                        scan_next  = '0;
                        state_next = S_CHOOSE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            mode_reg      <= MODE_INDEX;
            state_reg     <= S_IDLE;
            dg_chunk_reg  <= '0;
            deg_valid_reg <= '0;
            run_valid_reg <= '0;
            colored_reg   <= '0;
            scan_reg      <= '0;
            pipe_vld_reg  <= 1'b0;
            found_reg     <= 1'b0;
            tries_reg     <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            mode_reg      <= mode_next;
            state_reg     <= state_next;
            dg_chunk_reg  <= dg_chunk_next;
            deg_valid_reg <= deg_valid_next;
            run_valid_reg <= run_valid_next;
            colored_reg   <= colored_next;
            scan_reg      <= scan_next;
            pipe_vld_reg  <= pipe_vld_next;
            found_reg     <= found_next;
            tries_reg     <= tries_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dg_row_reg     <= dg_row_next;
        dg_cnt_reg     <= dg_cnt_next;
        dg_addr_reg    <= dg_addr_next;
        dg_ok_reg      <= dg_ok_next;
        pipe_idx_reg   <= pipe_idx_next;
        best_reg       <= best_next;
        best_key_reg   <= best_key_next;
        adjv_reg       <= adjv_next;
        used_reg       <= used_next;
        j_reg          <= j_next;
        color_reg      <= color_next;
        out_vertex_reg <= out_vertex_next;
        out_color_reg  <= out_color_next;
        out_tries_reg  <= out_tries_next;
        out_last_reg   <= out_last_next;
    end

    // Result channel.
    assign result.valid  = out_valid_reg;
    assign result.vertex = VERTEX_W'(out_vertex_reg);
    assign result.color  = COLOR_W'(out_color_reg);
    assign result.tries  = out_tries_reg;
    assign result.last   = out_last_reg;

    // A start clears the colored set and the try count before the first scan.
    `GGC_ASSERT_NEXT(a_start_clears, start_acc, (colored_reg == '0) && (tries_reg == '0),
        "start did not clear the run state")
    // The vertex picked by a scan is never one already painted.
    `GGC_ASSERT_NOW(a_pick_uncolored, state_reg == S_LATCH, !colored_reg[best_reg],
        "chosen vertex is already colored")
    // Neighbor updates stay inside the active vertex range.
    `GGC_ASSERT_NOW(a_update_range, run_we, pipe_idx_reg <= n_m1,
        "run store written beyond the vertex count")
    // A color never reaches the vertex count.
    `GGC_ASSERT_NOW(a_color_range, state_reg == S_EMIT, color_reg <= n_m1,
        "assigned color out of range")

endmodule
